// ----- rtl/life_pkg.sv -----
// Shared types, constants and helpers for the life automaton generation block.
// Depends on nothing.
package life_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int POS_W    = 6;
  localparam int SIZE_W   = 7;
  localparam int CMP_W    = 12;
  localparam int CNT_W    = 13;
  localparam int TOTAL_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_GEN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(64);

  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(MAX_ROWS - 1);
  localparam logic [COL_AW-1:0] LAST_COL = COL_AW'(MAX_COLS - 1);

  typedef logic [MAX_COLS-1:0] row_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL_RD,
    S_CELL_WB,
    S_GEN_FILL0,
    S_GEN_FILL1,
    S_GEN_FILL2,
    S_GEN_CELL,
    S_GEN_ROW_END,
    S_GEN_ROW_LD,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic alive;
    logic born;
    logic died;
  } cell_res_t;

  function automatic row_word_t row_mask(input row_word_t data, input logic [CMP_W-1:0] lim);
    row_word_t m;
    for (int i = 0; i < MAX_COLS; i++) begin
      m[i] = data[i] & (CMP_W'(i) < lim);
    end
    return m;
  endfunction

endpackage

// ----- rtl/life_cell_unit.sv -----
// Shared cell update unit: counts eight neighbors and applies the B3/S23 rule.
// Depends on life_pkg.
module life_cell_unit import life_pkg::*; (
  input  logic [2:0] top,
  input  logic [2:0] mid,
  input  logic [2:0] bot,
  input  logic       active,
  output cell_res_t  res
);

  logic [3:0] sum;
  logic       now;
  logic       nxt;

  assign sum = 4'(top[0]) + 4'(top[1]) + 4'(top[2]) + 4'(mid[0]) + 4'(mid[2])
             + 4'(bot[0]) + 4'(bot[1]) + 4'(bot[2]);
  assign now = mid[1];
  assign nxt = active & ((sum == 4'd3) | ((sum == 4'd2) & now));

  always_comb begin
    res.alive = nxt;
    res.born  = active & ~now & nxt;
    res.died  = active & now & ~nxt;
  end

endmodule

// ----- rtl/life_automaton_generation_top.sv -----
// Top level of the life automaton generation block: sequencer, grid memory, counters.
// Depends on life_pkg and life_cell_unit.
//
// Usage: one request on the input channel (kind, row, col, alive_in) gives one
// result on the output channel (alive_out, births, deaths, total_births).
// A request is taken when in_valid is high and in_stall is low; a result is taken
// when out_valid is high and out_stall is low. The grid is a memory of one
// 64-bit word per row. A cell write or read passes through read, update and finish
// states in that order. A generation fills the row window, then walks all 64 x 64
// cells through one shared cell unit, one cell a cycle, with a write back and a
// reload step after each row and a finish step at the end. in_stall stays high
// while a request is in work.
// After reset a clearing pass writes every row dead before the first
// request is taken; configuration writes are taken at any time (cfg_ready high).
// A stalled result holds in the output register; the next request can already be
// taken and worked, and waits at its end until the output register is free.
module life_automaton_generation_top import life_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic [POS_W-1:0]     row,
  input  logic [POS_W-1:0]     col,
  input  logic                 alive_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 alive_out,
  output logic [CNT_W-1:0]     births,
  output logic [CNT_W-1:0]     deaths,
  output logic [TOTAL_W-1:0]   total_births,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  state_t state, state_next;

  logic [SIZE_W-1:0]  rows_used;
  logic [SIZE_W-1:0]  cols_used;
  logic [CMP_W-1:0]   nr;
  logic [CMP_W-1:0]   nc;

  logic [1:0]         kind_q;
  logic [POS_W-1:0]   row_q;
  logic [POS_W-1:0]   col_q;
  logic               val_q;
  logic               res_alive;
  logic               in_area;

  logic [ROW_AW-1:0]  r;
  logic [COL_AW-1:0]  c;
  logic [CMP_W-1:0]   r2;
  logic               r2_ok;

  row_word_t          prev_row;
  row_word_t          cur_row;
  row_word_t          nxt_row;
  row_word_t          new_row;
  row_word_t          cell_word;

  logic [CNT_W-1:0]   birth_cnt;
  logic [CNT_W-1:0]   death_cnt;
  logic [TOTAL_W-1:0] birth_total;

  row_word_t          mem [MAX_ROWS];
  row_word_t          rd_data;
  logic               rd_en;
  logic [ROW_AW-1:0]  rd_addr;
  logic               wr_en;
  logic [ROW_AW-1:0]  wr_addr;
  row_word_t          wr_data;

  logic [MAX_COLS+1:0] pad_top;
  logic [MAX_COLS+1:0] pad_mid;
  logic [MAX_COLS+1:0] pad_bot;
  logic                cell_active;
  cell_res_t           cell_res;

  logic accept;
  logic out_free;

  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;
  assign cfg_ready = 1'b1;

  assign nr = (CMP_W'(rows_used) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : CMP_W'(rows_used);
  assign nc = (CMP_W'(cols_used) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS) : CMP_W'(cols_used);

  assign in_area = (CMP_W'(row_q) < nr) & (CMP_W'(col_q) < nc);
  assign r2      = CMP_W'(r) + CMP_W'(2);
  assign r2_ok   = r2 < CMP_W'(MAX_ROWS);

  assign pad_top     = {1'b0, prev_row, 1'b0};
  assign pad_mid     = {1'b0, cur_row, 1'b0};
  assign pad_bot     = {1'b0, nxt_row, 1'b0};
  assign cell_active = (CMP_W'(r) < nr) & (CMP_W'(c) < nc);

  life_cell_unit u_cell (
    .top    (pad_top[c +: 3]),
    .mid    (pad_mid[c +: 3]),
    .bot    (pad_bot[c +: 3]),
    .active (cell_active),
    .res    (cell_res)
  );

  always_comb begin
    cell_word = rd_data;
    cell_word[COL_AW'(col_q)] = val_q;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:       if (r == LAST_ROW) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_WRITE || kind == KIND_READ) begin
            state_next = S_CELL_RD;
          end else if (kind == KIND_GEN) begin
            state_next = S_GEN_FILL0;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_CELL_RD:     state_next = S_CELL_WB;
      S_CELL_WB:     state_next = S_FINISH;
      S_GEN_FILL0:   state_next = S_GEN_FILL1;
      S_GEN_FILL1:   state_next = S_GEN_FILL2;
      S_GEN_FILL2:   state_next = S_GEN_CELL;
      S_GEN_CELL:    if (c == LAST_COL) state_next = S_GEN_ROW_END;
      S_GEN_ROW_END: state_next = S_GEN_ROW_LD;
      S_GEN_ROW_LD:  state_next = (r == LAST_ROW) ? S_FINISH : S_GEN_CELL;
      S_FINISH:      if (out_free) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    rd_en    = 1'b0;
    rd_addr  = r;
    wr_en    = 1'b0;
    wr_addr  = r;
    wr_data  = new_row;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      S_CELL_RD: begin
        rd_en   = 1'b1;
        rd_addr = ROW_AW'(row_q);
      end
      S_CELL_WB: begin
        wr_en   = (kind_q == KIND_WRITE) & in_area;
        wr_addr = ROW_AW'(row_q);
        wr_data = cell_word;
      end
      S_GEN_FILL0: begin
        rd_en   = 1'b1;
        rd_addr = ROW_AW'(0);
      end
      S_GEN_FILL1: begin
        rd_en   = 1'b1;
        rd_addr = ROW_AW'(1);
      end
      S_GEN_ROW_END: begin
        wr_en   = 1'b1;
        rd_en   = r2_ok;
        rd_addr = r2[ROW_AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      rows_used   <= ROWS_RESET;
      cols_used   <= COLS_RESET;
      r           <= '0;
      c           <= '0;
      out_valid   <= 1'b0;
      birth_cnt   <= '0;
      death_cnt   <= '0;
      birth_total <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS) rows_used <= cfg_data;
        if (cfg_index == REG_COLS) cols_used <= cfg_data;
      end

      if (out_valid && !out_stall && state != S_FINISH) out_valid <= 1'b0;

      if (accept) begin
        kind_q    <= kind;
        row_q     <= row;
        col_q     <= col;
        val_q     <= alive_in;
        res_alive <= 1'b0;
        birth_cnt <= '0;
        death_cnt <= '0;
      end

      unique case (state)
        S_CLEAR: r <= (r == LAST_ROW) ? '0 : r + ROW_AW'(1);
        S_CELL_WB: begin
          if (kind_q == KIND_WRITE) begin
            res_alive <= in_area & val_q;
          end else begin
            res_alive <= in_area & rd_data[COL_AW'(col_q)];
          end
        end
        S_GEN_FILL1: cur_row <= (CMP_W'(0) < nr) ? row_mask(rd_data, nc) : '0;
        S_GEN_FILL2: begin
          nxt_row  <= (CMP_W'(1) < nr) ? row_mask(rd_data, nc) : '0;
          prev_row <= '0;
          r        <= '0;
          c        <= '0;
        end
        S_GEN_CELL: begin
          new_row[c] <= cell_res.alive;
          birth_cnt  <= birth_cnt + CNT_W'(cell_res.born);
          death_cnt  <= death_cnt + CNT_W'(cell_res.died);
          c          <= (c == LAST_COL) ? '0 : c + COL_AW'(1);
        end
        S_GEN_ROW_LD: begin
          prev_row <= cur_row;
          cur_row  <= nxt_row;
          nxt_row  <= (r2_ok && r2 < nr) ? row_mask(rd_data, nc) : '0;
          if (r == LAST_ROW) begin
            r           <= '0;
            birth_total <= birth_total + TOTAL_W'(birth_cnt);
          end else begin
            r <= r + ROW_AW'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            alive_out    <= res_alive;
            births       <= birth_cnt;
            deaths       <= death_cnt;
            total_births <= birth_total;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- tb/life_automaton_generation_top_tb.sv -----
// Testbench for life_automaton_generation_top: cell writes, reads and generations
// checked against a behavioral grid model in a small scoreboard class.
// Depends on life_pkg and the block's RTL.
module life_automaton_generation_top_tb import life_pkg::*; ();

  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3  = CFG_IDX_W'(3);
  localparam int CYCLE_LIMIT = 2_500_000;

  typedef struct packed {
    logic               alive;
    logic [CNT_W-1:0]   births;
    logic [CNT_W-1:0]   deaths;
    logic [TOTAL_W-1:0] total;
  } life_result_t;

  class life_scoreboard;
    bit                 cells [MAX_ROWS][MAX_COLS];
    logic [SIZE_W-1:0]  rows_cfg;
    logic [SIZE_W-1:0]  cols_cfg;
    logic [TOTAL_W-1:0] birth_sum;
    life_result_t       pending_results [$];
    int                 mismatch_count;

    function new();
      foreach (cells[i, j]) cells[i][j] = 1'b0;
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      birth_sum = '0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      if (idx == REG_ROWS) rows_cfg = data;
      else if (idx == REG_COLS) cols_cfg = data;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_request(logic [1:0] k, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                               logic a);
      life_result_t res;
      bit nxt [MAX_ROWS][MAX_COLS];
      int er, ec, sum, born, died, ni, nj;
      bit in_area, now_c, nxt_c;
      er = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
      ec = (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
      in_area = (int'(r) < er) && (int'(c) < ec);
      res = '0;
      born = 0;
      died = 0;
      case (k)
        KIND_WRITE: if (in_area) begin
          cells[r][c] = a;
          res.alive = a;
        end
        KIND_READ: if (in_area) res.alive = cells[r][c];
        KIND_GEN: begin
          for (int i = 0; i < MAX_ROWS; i++) begin
            for (int j = 0; j < MAX_COLS; j++) begin
              nxt[i][j] = 1'b0;
              if (i < er && j < ec) begin
                sum = 0;
                for (int di = -1; di <= 1; di++) begin
                  for (int dj = -1; dj <= 1; dj++) begin
                    ni = i + di;
                    nj = j + dj;
                    if ((di != 0 || dj != 0) && ni >= 0 && nj >= 0 && ni < er && nj < ec)
                      sum += cells[ni][nj];
                  end
                end
                now_c = cells[i][j];
                nxt_c = (sum == 3) || (sum == 2 && now_c);
                if (!now_c && nxt_c) born++;
                if (now_c && !nxt_c) died++;
                nxt[i][j] = nxt_c;
              end
            end
          end
          cells = nxt;
          birth_sum += TOTAL_W'(born);
          res.births = CNT_W'(born);
          res.deaths = CNT_W'(died);
        end
        default: ;
      endcase
      res.total = birth_sum;
      pending_results.push_back(res);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_result(logic alive, logic [CNT_W-1:0] b, logic [CNT_W-1:0] d,
                      logic [TOTAL_W-1:0] t);
      life_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result alive %0b births %0d deaths %0d total %0d",
                         alive, b, d, t));
        return;
      end
      want = pending_results.pop_front();
      if (alive !== want.alive)
        report($sformatf("alive_out got %0b want %0b", alive, want.alive));
      if (b !== want.births)
        report($sformatf("births got %0d want %0d", b, want.births));
      if (d !== want.deaths)
        report($sformatf("deaths got %0d want %0d", d, want.deaths));
      if (t !== want.total)
        report($sformatf("total_births got %0d want %0d", t, want.total));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           kind;
  logic [POS_W-1:0]     row;
  logic [POS_W-1:0]     col;
  logic                 alive_in;
  logic                 out_valid;
  logic                 out_stall;
  logic                 alive_out;
  logic [CNT_W-1:0]     births;
  logic [CNT_W-1:0]     deaths;
  logic [TOTAL_W-1:0]   total_births;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  life_scoreboard sb = new();
  bit tx_quiet;
  bit rx_quiet;
  bit want_hold;
  int cycles;

  life_automaton_generation_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .row          (row),
    .col          (col),
    .alive_in     (alive_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .alive_out    (alive_out),
    .births       (births),
    .deaths       (deaths),
    .total_births (total_births),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_WRITE;
    row = '0;
    col = '0;
    alive_in = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data = '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    want_hold = 1'b0;
    cycles = 0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (want_hold && hold_left == 0) begin
        hold_left = 400;
        want_hold = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (!rx_quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 13);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(alive_out, births, deaths, total_births);
    end
  end

  task automatic send_request(input logic [1:0] k, input int r, input int c, input bit a);
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    row = r[POS_W-1:0];
    col = c[POS_W-1:0];
    alive_in = a;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, row, col, alive_in);
  endtask

  task automatic sender_gap();
    int n;
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value[SIZE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(cfg_index, cfg_data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int rows_set, cols_set, er, ec, wsr, wsc, wr0, wc0, sel, r, c;
    bit a;
    logic [1:0] k;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: corners, top-edge blinker, unused kind, kill, sizes zero and saturated
    send_request(KIND_READ, 0, 0, 1'b0);
    send_request(KIND_GEN, 0, 0, 1'b0);
    send_request(KIND_WRITE, 0, 0, 1'b1);
    send_request(KIND_WRITE, 63, 63, 1'b1);
    send_request(KIND_WRITE, 63, 0, 1'b1);
    send_request(KIND_WRITE, 0, 63, 1'b1);
    send_request(KIND_WRITE, 0, 10, 1'b1);
    send_request(KIND_WRITE, 0, 11, 1'b1);
    send_request(KIND_WRITE, 0, 12, 1'b1);
    send_request(KIND_GEN, 0, 0, 1'b0);
    send_request(KIND_READ, 1, 11, 1'b0);
    send_request(KIND_READ, 0, 10, 1'b0);
    send_request(KIND_UNUSED, 63, 63, 1'b1);
    send_request(KIND_WRITE, 1, 11, 1'b0);
    send_request(KIND_READ, 63, 63, 1'b0);
    write_reg(REG_ROWS, 0);
    send_request(KIND_WRITE, 5, 5, 1'b1);
    send_request(KIND_GEN, 0, 0, 1'b0);
    send_request(KIND_READ, 0, 11, 1'b0);
    write_reg(REG_ROWS, 127);
    write_reg(REG_COLS, 127);
    send_request(KIND_READ, 0, 11, 1'b0);
    send_request(KIND_WRITE, 5, 5, 1'b1);
    send_request(KIND_WRITE, 5, 6, 1'b1);
    send_request(KIND_WRITE, 6, 5, 1'b1);
    send_request(KIND_GEN, 0, 0, 1'b0);
    write_reg(REG_COLS, 0);
    send_request(KIND_READ, 5, 5, 1'b0);
    write_reg(REG_SPARE2, $urandom_range(0, 127));
    write_reg(REG_SPARE3, $urandom_range(0, 127));

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin rows_set = 8;   cols_set = 8;   end
        1: begin rows_set = 1;   cols_set = 64;  end
        2: begin rows_set = 64;  cols_set = 1;   end
        3: begin rows_set = 3;   cols_set = 3;   end
        4: begin rows_set = 127; cols_set = 127; end
        5: begin rows_set = 12;  cols_set = 40;  end
        6: begin rows_set = $urandom_range(0, 127); cols_set = $urandom_range(0, 127); end
        default: begin rows_set = $urandom_range(2, 20); cols_set = $urandom_range(2, 20); end
      endcase
      write_reg(REG_ROWS, rows_set);
      write_reg(REG_COLS, cols_set);
      tx_quiet = (p == 2) || (p == 7);
      rx_quiet = (p == 7);
      if (p == 2) want_hold = 1'b1;
      er = (rows_set > MAX_ROWS) ? MAX_ROWS : rows_set;
      ec = (cols_set > MAX_COLS) ? MAX_COLS : cols_set;
      wsr = (er > 8) ? 8 : er;
      wsc = (ec > 8) ? 8 : ec;
      wr0 = (er > 0) ? $urandom_range(0, er - wsr) : 0;
      wc0 = (ec > 0) ? $urandom_range(0, ec - wsc) : 0;
      repeat (15) begin
        sel = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) < 7);
        if (er == 0 || ec == 0 || $urandom_range(0, 9) == 0) begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
        end else begin
          r = wr0 + $urandom_range(0, wsr - 1);
          c = wc0 + $urandom_range(0, wsc - 1);
        end
        if (sel < 55) k = KIND_WRITE;
        else if (sel < 70) k = KIND_GEN;
        else if (sel < 95) k = KIND_READ;
        else begin
          k = KIND_UNUSED;
          a = $urandom_range(0, 1);
        end
        send_request(k, r, c, a);
        sender_gap();
      end
    end

    drain();
    repeat (30) @(posedge clk);
    if (sb.mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- life_automaton_generation_top.f -----
rtl/life_pkg.sv
rtl/life_cell_unit.sv
rtl/life_automaton_generation_top.sv
tb/life_automaton_generation_top_tb.sv
